// ----- rtl/core/mct_pkg.sv -----
// Shared types, widths and helper functions for the mesh coordinate to index block.
// Used by mct_lane, mct_merge and mesh_coordinate_to_index_top. No other dependencies.
package mct_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int MAX_MESH    = 256;
  localparam int COORD_W     = 28;
  localparam int SHIFT_W     = 24;
  localparam int TOL_W       = 24;
  localparam int SIZE_CFG_W  = 9;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int FLAT_W      = 24;

  localparam int SIZE_W      = $clog2(MAX_MESH + 1);
  localparam int IDX_W       = $clog2(MAX_MESH);
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = FRAC_BITS + SIZE_W;
  localparam int MIS_W       = FRAC_BITS;
  localparam int SUM_W       = MIS_W + 2;
  localparam int CMP_W       = (SUM_W > TOL_W) ? SUM_W : TOL_W;
  localparam int YZ_W        = IDX_W + SIZE_W;
  localparam int FLAT_FULL_W = YZ_W + SIZE_W;

  localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X  = 3'd0,
    REG_SIZE_Y  = 3'd1,
    REG_SIZE_Z  = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5,
    REG_TOL     = 3'd6
  } cfg_reg_t;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [MIS_W-1:0]  mis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } point_t;

  typedef struct packed {
    logic [FLAT_W-1:0] flat_index;
    logic              on_mesh;
  } result_t;

  // Load enables of the three lane stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctl_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    idx_t idx;
    mis_t misfit;
  } lane_res_t;

  // A size of zero counts as one; sizes above the mesh limit saturate.
  function automatic size_t eff_size(input logic [SIZE_CFG_W-1:0] n);
    if (n == '0) begin
      return SIZE_W'(1);
    end else if (int'(n) > MAX_MESH) begin
      return SIZE_W'(MAX_MESH);
    end else begin
      return SIZE_W'(n);
    end
  endfunction

endpackage

// ----- rtl/core/mct_lane.sv -----
// One axis lane: offset subtract, scale by mesh size, round, misfit and fold.
// Three register stages. Depends on mct_pkg.
module mct_lane (
  input  logic                              clk,
  input  mct_pkg::lane_ctl_t                ctl,
  input  logic signed [mct_pkg::COORD_W-1:0] coord,
  input  logic [mct_pkg::SHIFT_W-1:0]       shift,
  input  mct_pkg::size_t                    size,
  output mct_pkg::lane_res_t                res
);
  import mct_pkg::*;

  logic [DIFF_W-1:0]    diff;
  logic [FRAC_BITS-1:0] frac1;
  logic                 neg1;
  logic [PROD_W-1:0]    prod2;
  logic                 neg2;
  logic [FRAC_BITS-1:0] lo;
  logic [FRAC_BITS-1:0] lo_neg;
  size_t                whole;
  size_t                rnd;
  logic                 up;
  lane_res_t            res_next;

  // Only the fraction of the difference and its sign matter: the integer part
  // times the size is a multiple of the size and drops out of the fold.
  assign diff = {coord[COORD_W-1], coord} - {{(DIFF_W-SHIFT_W){1'b0}}, shift};

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      frac1 <= diff[FRAC_BITS-1:0];
      neg1  <= diff[DIFF_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prod2 <= {{SIZE_W{1'b0}}, frac1} * {{FRAC_BITS{1'b0}}, size};
      neg2  <= neg1;
    end
  end

  // Halves round away from zero, so a negative point rounds up only past half.
  always_comb begin
    lo     = prod2[FRAC_BITS-1:0];
    whole  = prod2[PROD_W-1:FRAC_BITS];
    up     = neg2 ? (lo > FRAC_HALF) : (lo >= FRAC_HALF);
    rnd    = whole + {{(SIZE_W-1){1'b0}}, up};
    lo_neg = ~lo + {{(FRAC_BITS-1){1'b0}}, 1'b1};
    res_next.misfit = up ? lo_neg : lo;
    res_next.idx    = (rnd == size) ? '0 : rnd[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/core/mct_merge.sv -----
// Merge stage: sums the lane misfits, tests the tolerance and flattens the indices.
// Holds the output register. Depends on mct_pkg.
module mct_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s3_valid,
  output logic                          s3_ready,
  input  mct_pkg::lane_res_t            res_x,
  input  mct_pkg::lane_res_t            res_y,
  input  mct_pkg::lane_res_t            res_z,
  input  mct_pkg::size_t                size_x,
  input  mct_pkg::size_t                size_y,
  input  mct_pkg::size_t                size_z,
  input  logic [mct_pkg::TOL_W-1:0]     tol,
  output logic                          result_valid,
  input  logic                          result_ready,
  output mct_pkg::result_t              result
);
  import mct_pkg::*;

  logic                   ld4;
  logic                   ld5;
  logic                   s4_valid;
  logic [SUM_W-1:0]       sum;
  logic                   on_next;
  logic [YZ_W-1:0]        yz_next;
  logic                   on4;
  logic [YZ_W-1:0]        yz4;
  idx_t                   ix4;
  logic [FLAT_FULL_W-1:0] flat_full;
  result_t                result_next;

  assign ld5      = !result_valid || result_ready;
  assign ld4      = !s4_valid || ld5;
  assign s3_ready = ld4;

  always_comb begin
    sum = {2'b00, res_x.misfit} + {2'b00, res_y.misfit} + {2'b00, res_z.misfit};
    on_next = CMP_W'(sum) < CMP_W'(tol);
    yz_next = ({{SIZE_W{1'b0}}, res_z.idx} * {{IDX_W{1'b0}}, size_y})
            + {{SIZE_W{1'b0}}, res_y.idx};
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      on4 <= on_next;
      yz4 <= yz_next;
      ix4 <= res_x.idx;
    end
  end

  always_comb begin
    flat_full = ({{SIZE_W{1'b0}}, yz4} * {{YZ_W{1'b0}}, size_x})
              + {{(FLAT_FULL_W-IDX_W){1'b0}}, ix4};
    result_next.on_mesh    = on4;
    result_next.flat_index = on4 ? flat_full[FLAT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ld4) begin
        s4_valid <= s3_valid;
      end
      if (ld5) begin
        result_valid <= s4_valid;
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ({1'b0, res_x.idx} < size_x) && ({1'b0, res_y.idx} < size_y)
                 && ({1'b0, res_z.idx} < size_z))
    else $error("lane index outside the mesh");

  a_misfit_half: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (res_x.misfit <= FRAC_HALF) && (res_y.misfit <= FRAC_HALF)
                 && (res_z.misfit <= FRAC_HALF))
    else $error("lane misfit above one half");

  a_off_mesh_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.on_mesh |-> result.flat_index == '0)
    else $error("off-mesh word carries a nonzero index");

endmodule

// ----- rtl/core/mesh_coordinate_to_index_top.sv -----
// Top level of the mesh coordinate to index block: configuration registers,
// three axis lanes and the merge stage. Depends on mct_pkg, mct_lane, mct_merge.
//
// Usage:
//   A point word (coord_x, coord_y, coord_z, signed with 24 fraction bits)
//   enters on the point channel with point_valid/point_ready. One result word
//   (flat_index, on_mesh) leaves on the result channel for every point, in
//   order. Each axis runs in its own lane; the merge stage adds the three
//   misfits, compares against the tolerance and flattens x fastest.
//   The accepting edge loads lane stage one; lane stages two and three, the
//   merge stage and the output register, which drives result_valid, follow.
//   One point per cycle when nothing stalls; every stage is pipelined.
//   When the receiver holds result_ready low the output register keeps its
//   word, and stages behind it keep filling until every stage is occupied;
//   only then does point_ready drop.
//   Configuration words on the cfg channel are always taken (cfg_ready is
//   high) and must only be written while no point is in flight. Index 0..2
//   are the mesh sizes, 3..5 the offsets, 6 the misfit tolerance; index 7 is
//   ignored. Synchronous reset empties the pipeline and restores sizes of one,
//   zero offsets and a tolerance of 17.
module mesh_coordinate_to_index_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             point_valid,
  output logic                             point_ready,
  input  mct_pkg::point_t                  point,
  output logic                             result_valid,
  input  logic                             result_ready,
  output mct_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mct_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mct_pkg::*;

  logic [SIZE_CFG_W-1:0] size_x;
  logic [SIZE_CFG_W-1:0] size_y;
  logic [SIZE_CFG_W-1:0] size_z;
  logic [SHIFT_W-1:0]    shift_x;
  logic [SHIFT_W-1:0]    shift_y;
  logic [SHIFT_W-1:0]    shift_z;
  logic [TOL_W-1:0]      tol;

  size_t     nx;
  size_t     ny;
  size_t     nz;
  logic      s1_valid;
  logic      s2_valid;
  logic      s3_valid;
  logic      s3_ready;
  lane_ctl_t ctl;
  lane_res_t res_x;
  lane_res_t res_y;
  lane_res_t res_z;

  // Configuration is never back-pressured.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x  <= SIZE_CFG_W'(1);
      size_y  <= SIZE_CFG_W'(1);
      size_z  <= SIZE_CFG_W'(1);
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
      tol     <= TOL_W'(17);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X:  size_x  <= cfg_data[SIZE_CFG_W-1:0];
        REG_SIZE_Y:  size_y  <= cfg_data[SIZE_CFG_W-1:0];
        REG_SIZE_Z:  size_z  <= cfg_data[SIZE_CFG_W-1:0];
        REG_SHIFT_X: shift_x <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Y: shift_y <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Z: shift_z <= cfg_data[SHIFT_W-1:0];
        REG_TOL:     tol     <= cfg_data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The user must hold the effective sizes constant while points are in flight;
  // the block does not enforce this, and every stage reads them directly.
  assign nx = eff_size(size_x);
  assign ny = eff_size(size_y);
  assign nz = eff_size(size_z);

  // A stage loads when it is empty or when the stage after it is loading.
  always_comb begin
    ctl.ld3     = !s3_valid || s3_ready;
    ctl.ld2     = !s2_valid || ctl.ld3;
    ctl.ld1     = !s1_valid || ctl.ld2;
    point_ready = ctl.ld1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ctl.ld1) begin
        s1_valid <= point_valid;
      end
      if (ctl.ld2) begin
        s2_valid <= s1_valid;
      end
      if (ctl.ld3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  mct_lane u_lane_x (
    .clk   (clk),
    .ctl   (ctl),
    .coord (point.coord_x),
    .shift (shift_x),
    .size  (nx),
    .res   (res_x)
  );

  mct_lane u_lane_y (
    .clk   (clk),
    .ctl   (ctl),
    .coord (point.coord_y),
    .shift (shift_y),
    .size  (ny),
    .res   (res_y)
  );

  mct_lane u_lane_z (
    .clk   (clk),
    .ctl   (ctl),
    .coord (point.coord_z),
    .shift (shift_z),
    .size  (nz),
    .res   (res_z)
  );

  mct_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .s3_valid     (s3_valid),
    .s3_ready     (s3_ready),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .size_x       (nx),
    .size_y       (ny),
    .size_z       (nz),
    .tol          (tol),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> s1_valid)
    else $error("accepted point word did not enter the first stage");

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_index == REG_SIZE_X) && (cfg_data[SIZE_CFG_W-1:0] == '0)
    |=> nx == SIZE_W'(1))
    else $error("mesh size of zero not treated as one");

endmodule
